[rtl/tdss_pkg.sv]
// Shared types, constants and segment tables for the three-digit display serializer.
// No dependencies.
package tdss_pkg;

  localparam int WORD_BITS = 32;
  localparam int POS_W     = $clog2(WORD_BITS);
  localparam int VALUE_W   = 16;
  localparam int LEVEL_W   = 4;
  localparam int DIGIT_W   = 4;
  localparam int Q10_W     = 13;
  localparam int Q100_W    = 10;
  localparam int Q1000_W   = 7;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [VALUE_W-1:0]   value_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [DIGIT_W-1:0]   digit_t;

  localparam pos_t   POS_LAST  = pos_t'(WORD_BITS - 1);
  localparam pos_t   POS_ONE   = pos_t'(1);
  localparam level_t LEVEL_MAX = level_t'(8);

  // x / 10 as (x * 52429) >> 19, exact for x below 2**16
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;
  // x / 10 as (x * 205) >> 11, exact for x below 1029
  localparam logic [7:0]  DIV10_MUL_S   = 8'd205;
  localparam int          DIV10_SHIFT_S = 11;

  typedef struct packed {
    logic busy;
    logic word_valid;
  } front_stat_t;

  function automatic word_t hundreds_seg(input digit_t d);
    word_t w;
    case (d)
      4'd0:    w = 32'h7007_0000;
      4'd1:    w = 32'h4001_0000;
      4'd2:    w = 32'h300B_0000;
      4'd3:    w = 32'h600B_0000;
      4'd4:    w = 32'h400D_0000;
      4'd5:    w = 32'h600E_0000;
      4'd6:    w = 32'h700E_0000;
      4'd7:    w = 32'h4003_0000;
      4'd8:    w = 32'h700F_0000;
      4'd9:    w = 32'h600F_0000;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic word_t tens_seg(input digit_t d);
    word_t w;
    case (d)
      4'd0:    w = 32'h0000_0770;
      4'd1:    w = 32'h0000_0410;
      4'd2:    w = 32'h0000_03B0;
      4'd3:    w = 32'h0000_06B0;
      4'd4:    w = 32'h0000_04D0;
      4'd5:    w = 32'h0000_06E0;
      4'd6:    w = 32'h0000_07E0;
      4'd7:    w = 32'h0000_0430;
      4'd8:    w = 32'h0000_07F0;
      4'd9:    w = 32'h0000_06F0;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic word_t ones_seg(input digit_t d);
    word_t w;
    case (d)
      4'd0:    w = 32'h0000_7007;
      4'd1:    w = 32'h0000_4001;
      4'd2:    w = 32'h0000_300B;
      4'd3:    w = 32'h0000_600B;
      4'd4:    w = 32'h0000_400D;
      4'd5:    w = 32'h0000_600E;
      4'd6:    w = 32'h0000_700E;
      4'd7:    w = 32'h0000_4003;
      4'd8:    w = 32'h0000_700F;
      4'd9:    w = 32'h0000_600F;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic word_t bar_seg(input level_t lvl);
    word_t w;
    case (lvl)
      4'd0:    w = 32'h0000_0000;
      4'd1:    w = 32'h0100_0000;
      4'd2:    w = 32'h0300_0000;
      4'd3:    w = 32'h0700_0000;
      4'd4:    w = 32'h0F00_0000;
      4'd5:    w = 32'h0F80_0000;
      4'd6:    w = 32'h0FC0_0000;
      4'd7:    w = 32'h0FE0_0000;
      default: w = 32'h0FF0_0000;
    endcase
    return w;
  endfunction

endpackage

[rtl/three_digit_segment_display_serializer.sv]
// Top level of the three-digit display serializer: front pipeline, cell chain, bit counter.
// Depends on tdss_pkg, tdss_word_build and tdss_cell.
//
// Each item (a value and a bar level) becomes one 32-bit display word that leaves as 32
// serial bits, least significant first, one per clock on consecutive cycles, with
// out_latch_pulse high on the last one. The first bit reaches the result ports once the
// item has passed the front pipeline and the word register and is loaded into the chain.
// A 32-cell shift chain moving one bit per clock paces the items; the bits of successive
// items follow without a gap when the next word is ready in time. busy drops as soon as
// a word enters the chain, so the next item can be taken while the current one is still
// shifting. The receiver cannot stall: each bit is shown for exactly one cycle under out_valid.
module three_digit_segment_display_serializer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [15:0]            in_display_value,
  input  logic [3:0]             in_bar_level,
  output logic                   out_valid,
  output logic                   out_data_bit,
  output logic [4:0]             out_bit_position,
  output logic                   out_latch_pulse
);

  tdss_pkg::front_stat_t          stat;
  tdss_pkg::word_t                word;
  logic                           accept;
  logic                           load;
  logic                           active_r;
  tdss_pkg::pos_t                 cnt_r;
  logic [tdss_pkg::WORD_BITS-1:0] cell_q;

  assign accept = start & ~stat.busy;
  assign busy   = stat.busy;
  assign load   = stat.word_valid & (~active_r | (cnt_r == tdss_pkg::POS_LAST));

  tdss_word_build u_word_build (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .display_value (in_display_value),
    .bar_level     (in_bar_level),
    .take          (load),
    .stat          (stat),
    .word          (word)
  );

  for (genvar i = 0; i < tdss_pkg::WORD_BITS; i++) begin : g_cell
    logic shift_in;
    if (i == tdss_pkg::WORD_BITS - 1) begin : g_end
      assign shift_in = 1'b0;
    end else begin : g_mid
      assign shift_in = cell_q[i+1];
    end
    tdss_cell u_cell (
      .clk      (clk),
      .load     (load),
      .load_bit (word[i]),
      .shift_in (shift_in),
      .bit_q    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (load) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (active_r) begin
      if (cnt_r == tdss_pkg::POS_LAST) begin
        active_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + tdss_pkg::POS_ONE;
      end
    end
  end

  assign out_valid        = active_r;
  assign out_data_bit     = cell_q[0];
  assign out_bit_position = cnt_r;
  assign out_latch_pulse  = active_r & (cnt_r == tdss_pkg::POS_LAST);

  a_bits_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && cnt_r != tdss_pkg::POS_LAST) |=>
      (active_r && cnt_r == $past(cnt_r) + tdss_pkg::POS_ONE))
    else $error("bit position did not advance within an item");

  a_word_ready : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 stat.word_valid)
    else $error("display word not ready four cycles after accept");

  a_idle_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && cnt_r == tdss_pkg::POS_LAST && !stat.word_valid) |=> !active_r)
    else $error("chain still active after last bit with no word waiting");

  a_next_starts_at_zero : assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (active_r && cnt_r == '0))
    else $error("new word did not start at bit position zero");

endmodule

[rtl/tdss_word_build.sv]
// Front pipeline: splits off the three low decimal digits of the value and builds the display word.
// Depends on tdss_pkg; holds the finished word until the cell chain takes it.
module tdss_word_build (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  tdss_pkg::value_t      display_value,
  input  tdss_pkg::level_t      bar_level,
  input  logic                  take,
  output tdss_pkg::front_stat_t stat,
  output tdss_pkg::word_t       word
);

  logic v1_r, v2_r, v3_r, wv_r;

  tdss_pkg::value_t                   val1_r;
  logic [tdss_pkg::Q10_W-1:0]         q10_1_r, q10_2_r;
  tdss_pkg::level_t                   lvl1_r, lvl2_r, lvl3_r;
  tdss_pkg::digit_t                   d0_2_r, d0_3_r, d1_3_r;
  logic [tdss_pkg::Q100_W-1:0]        q100_2_r, q100_3_r;
  logic [tdss_pkg::Q1000_W-1:0]       q1000_3_r;
  tdss_pkg::word_t                    word_r;

  logic [31:0]                        prod1;
  logic [28:0]                        prod2;
  logic [17:0]                        prod3;
  tdss_pkg::level_t                   lvl_sat;
  tdss_pkg::value_t                   d0_full;
  logic [tdss_pkg::Q10_W-1:0]         d1_full;
  logic [tdss_pkg::Q100_W-1:0]        d2_full;
  tdss_pkg::digit_t                   d0_nxt, d1_nxt, d2_nxt;
  tdss_pkg::word_t                    word_nxt;

  always_comb begin
    lvl_sat  = (bar_level > tdss_pkg::LEVEL_MAX) ? tdss_pkg::LEVEL_MAX : bar_level;
    prod1    = 32'(display_value) * 32'(tdss_pkg::DIV10_MUL);
    d0_full  = val1_r - (tdss_pkg::value_t'(q10_1_r) * tdss_pkg::value_t'(10));
    d0_nxt   = d0_full[tdss_pkg::DIGIT_W-1:0];
    prod2    = 29'(q10_1_r) * 29'(tdss_pkg::DIV10_MUL);
    d1_full  = q10_2_r - (tdss_pkg::Q10_W'(q100_2_r) * tdss_pkg::Q10_W'(10));
    d1_nxt   = d1_full[tdss_pkg::DIGIT_W-1:0];
    prod3    = 18'(q100_2_r) * 18'(tdss_pkg::DIV10_MUL_S);
    d2_full  = q100_3_r - (tdss_pkg::Q100_W'(q1000_3_r) * tdss_pkg::Q100_W'(10));
    d2_nxt   = d2_full[tdss_pkg::DIGIT_W-1:0];
    word_nxt = tdss_pkg::hundreds_seg(d2_nxt) | tdss_pkg::tens_seg(d1_3_r)
             | tdss_pkg::ones_seg(d0_3_r) | tdss_pkg::bar_seg(lvl3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      wv_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v3_r) begin
        wv_r <= 1'b1;
      end else if (take) begin
        wv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val1_r    <= display_value;
    q10_1_r   <= prod1[31:tdss_pkg::DIV10_SHIFT];
    lvl1_r    <= lvl_sat;
    d0_2_r    <= d0_nxt;
    q10_2_r   <= q10_1_r;
    q100_2_r  <= prod2[28:tdss_pkg::DIV10_SHIFT];
    lvl2_r    <= lvl1_r;
    d0_3_r    <= d0_2_r;
    d1_3_r    <= d1_nxt;
    q100_3_r  <= q100_2_r;
    q1000_3_r <= prod3[17:tdss_pkg::DIV10_SHIFT_S];
    lvl3_r    <= lvl2_r;
    if (v3_r) begin
      word_r <= word_nxt;
    end
  end

  assign stat.busy       = v1_r | v2_r | v3_r | wv_r;
  assign stat.word_valid = wv_r;
  assign word            = word_r;

endmodule

[rtl/tdss_cell.sv]
// One bit cell of the output chain: loads a word bit or takes its neighbor's bit each cycle.
// No dependencies.
module tdss_cell (
  input  logic clk,
  input  logic load,
  input  logic load_bit,
  input  logic shift_in,
  output logic bit_q
);

  logic bit_r;
  logic bit_nxt;

  assign bit_nxt = load ? load_bit : shift_in;

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
  end

  assign bit_q = bit_r;

endmodule

[verif/tdss_serial_checker.sv]
// Checker for the three-digit display serializer: watches the item and serial bit ports,
// predicts the 32 bits of each display word and compares them in order.
// Depends on tdss_pkg for the port types.
`timescale 1ns / 100ps

module tdss_serial_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  tdss_pkg::value_t in_display_value,
  input  tdss_pkg::level_t in_bar_level,
  input  logic             out_valid,
  input  logic             out_data_bit,
  input  tdss_pkg::pos_t   out_bit_position,
  input  logic             out_latch_pulse,
  output int               fail_count,
  output int               bits_pending
);

  typedef struct packed {
    logic           data_bit;
    tdss_pkg::pos_t position;
    logic           latch;
  } serial_bit_t;

  localparam tdss_pkg::word_t HUNDREDS_MAP [10] = '{
    32'h7007_0000, 32'h4001_0000, 32'h300B_0000, 32'h600B_0000, 32'h400D_0000,
    32'h600E_0000, 32'h700E_0000, 32'h4003_0000, 32'h700F_0000, 32'h600F_0000
  };
  localparam tdss_pkg::word_t TENS_MAP [10] = '{
    32'h0000_0770, 32'h0000_0410, 32'h0000_03B0, 32'h0000_06B0, 32'h0000_04D0,
    32'h0000_06E0, 32'h0000_07E0, 32'h0000_0430, 32'h0000_07F0, 32'h0000_06F0
  };
  localparam tdss_pkg::word_t ONES_MAP [10] = '{
    32'h0000_7007, 32'h0000_4001, 32'h0000_300B, 32'h0000_600B, 32'h0000_400D,
    32'h0000_600E, 32'h0000_700E, 32'h0000_4003, 32'h0000_700F, 32'h0000_600F
  };
  localparam tdss_pkg::word_t BAR_MAP [9] = '{
    32'h0000_0000, 32'h0100_0000, 32'h0300_0000, 32'h0700_0000, 32'h0F00_0000,
    32'h0F80_0000, 32'h0FC0_0000, 32'h0FE0_0000, 32'h0FF0_0000
  };

  serial_bit_t shift_queue[$];
  int          errors;

  function automatic tdss_pkg::word_t display_word(input tdss_pkg::value_t value,
                                                   input tdss_pkg::level_t level);
    int unsigned num;
    int unsigned lvl;
    num = value;
    lvl = (level > tdss_pkg::LEVEL_MAX) ? 8 : level;
    return HUNDREDS_MAP[(num / 100) % 10] | TENS_MAP[(num / 10) % 10] |
           ONES_MAP[num % 10] | BAR_MAP[lvl];
  endfunction

  initial begin
    errors = 0;
  end

  always @(posedge clk) begin
    serial_bit_t     want;
    tdss_pkg::word_t word;
    if (!rst_n) begin
      shift_queue.delete();
    end else begin
      if (out_valid) begin
        if (shift_queue.size() == 0) begin
          $error("bit with no item pending: position %0d", out_bit_position);
          errors++;
        end else begin
          want = shift_queue.pop_front();
          if (out_data_bit !== want.data_bit) begin
            $error("data_bit: expected %0d, got %0d", want.data_bit, out_data_bit);
            errors++;
          end
          if (out_bit_position !== want.position) begin
            $error("bit_position: expected %0d, got %0d", want.position, out_bit_position);
            errors++;
          end
          if (out_latch_pulse !== want.latch) begin
            $error("latch_pulse: expected %0d, got %0d", want.latch, out_latch_pulse);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        word = display_word(in_display_value, in_bar_level);
        for (int k = 0; k < tdss_pkg::WORD_BITS; k++) begin
          shift_queue.push_back('{word[k], tdss_pkg::pos_t'(k),
                                  k == tdss_pkg::WORD_BITS - 1});
        end
      end
    end
    fail_count   <= errors;
    bits_pending <= shift_queue.size();
  end

endmodule

[verif/three_digit_segment_display_serializer_tb.sv]
// Testbench top for the three-digit display serializer: clock, reset and item stimulus
// in random bursts; checking is left to tdss_serial_checker.
// Depends on tdss_pkg, the serializer and tdss_serial_checker.
`timescale 1ns / 100ps

module three_digit_segment_display_serializer_tb;

  localparam int RANDOM_ITEMS = 235;
  localparam int CYCLE_LIMIT  = 300000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  tdss_pkg::value_t in_display_value;
  tdss_pkg::level_t in_bar_level;
  logic             out_valid;
  logic             out_data_bit;
  tdss_pkg::pos_t   out_bit_position;
  logic             out_latch_pulse;
  int               fail_count;
  int               bits_pending;
  int               burst_left;

  three_digit_segment_display_serializer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_display_value (in_display_value),
    .in_bar_level     (in_bar_level),
    .out_valid        (out_valid),
    .out_data_bit     (out_data_bit),
    .out_bit_position (out_bit_position),
    .out_latch_pulse  (out_latch_pulse)
  );

  tdss_serial_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_display_value (in_display_value),
    .in_bar_level     (in_bar_level),
    .out_valid        (out_valid),
    .out_data_bit     (out_data_bit),
    .out_bit_position (out_bit_position),
    .out_latch_pulse  (out_latch_pulse),
    .fail_count       (fail_count),
    .bits_pending     (bits_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // hold start until the item is taken, then keep the burst going or drop into a gap
  task automatic send_item(input tdss_pkg::value_t value, input tdss_pkg::level_t level,
                           input bit drop);
    start            <= 1'b1;
    in_display_value <= value;
    in_bar_level     <= level;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (drop || burst_left == 0) begin
      start <= 1'b0;
      if (!drop) begin
        burst_left = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(0, 10);
        repeat (($urandom_range(0, 5) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30))
          @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    while (bits_pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    tdss_pkg::value_t dir_value [25] = '{
      16'd0, 16'd111, 16'd222, 16'd333, 16'd444, 16'd555, 16'd666, 16'd777, 16'd888,
      16'd999, 16'd1000, 16'd65535, 16'd65000, 16'd123, 16'd456, 16'd789, 16'd80,
      16'd8, 16'd800, 16'd1888, 16'd32768, 16'd9999, 16'd10, 16'd100, 16'd7
    };
    tdss_pkg::value_t value;
    tdss_pkg::level_t level;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_display_value = '0;
    in_bar_level     = '0;
    burst_left       = 3;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < 25; i++) begin
      send_item(dir_value[i], tdss_pkg::level_t'(i % 16), i == 24);
    end
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 3))
        0:       value = tdss_pkg::value_t'($urandom_range(0, 999));
        default: value = tdss_pkg::value_t'($urandom_range(0, 65535));
      endcase
      level = ($urandom_range(0, 2) == 0) ? tdss_pkg::level_t'($urandom_range(9, 15))
                                          : tdss_pkg::level_t'($urandom_range(0, 8));
      send_item(value, level, i == RANDOM_ITEMS / 2 || i == RANDOM_ITEMS - 1);
      if (i == RANDOM_ITEMS / 2) begin
        wait_drained();
      end
    end

    while (bits_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tdss_pkg.sv
rtl/tdss_word_build.sv
rtl/tdss_cell.sv
rtl/three_digit_segment_display_serializer.sv
verif/tdss_serial_checker.sv
verif/three_digit_segment_display_serializer_tb.sv
